>>> src/arim_pkg.sv
// Shared types and constants for the record input monitor.
`default_nettype none
package arim_pkg;
    localparam int CHANNELS_DEF = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam logic signed [16:0] FULL_SCALE = 17'sd32767;
    localparam logic signed [17:0] COMP_LIMIT = 18'sd65535;

    typedef enum logic [2:0] {
        OP_FRAME   = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_PEAK    = 3'd3,
        OP_DCAPPLY = 3'd4,
        OP_RESTART = 3'd5,
        OP_NONE6   = 3'd6,
        OP_NONE7   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        CFG_CHANNELS  = 3'd0,
        CFG_THR_EN    = 3'd1,
        CFG_THR_LEVEL = 3'd2,
        CFG_MAX_DUR   = 3'd3,
        CFG_DC_WINDOW = 3'd4
    } cfg_idx_t;

    // one classified request handed from front to back
    typedef struct packed {
        op_t                op;
        logic signed [15:0] smp_l;
        logic signed [15:0] smp_r;
        logic               peak_ch;
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;
endpackage
`default_nettype wire

>>> src/arim_front.sv
// Front end: input request capture into a short queue.
`default_nettype none
module arim_front
    import arim_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire req_t  in_req,
    output logic       q_valid,
    input  wire logic  q_ready,
    output req_t       q_req
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    req_t mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic push, pop;

    assign in_ready = (cnt_reg != (AW+1)'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_req;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == AW'(QUEUE_DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop) rp_reg <= (rp_reg == AW'(QUEUE_DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

>>> src/arim_div.sv
// Iterative signed divide of a 37-bit sum by a 20-bit count, truncating.
`default_nettype none
module arim_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [36:0] dividend,
    input  wire logic [19:0]        divisor,
    output logic                    busy,
    output logic signed [15:0]      quotient
);
    logic [36:0] rem_reg, quo_reg;
    logic [19:0] dsr_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic [37:0] trial;
    logic [36:0] rem_sh;
    logic [36:0] q_signed;

    assign rem_sh = {rem_reg[35:0], quo_reg[36]};
    assign trial  = {1'b0, rem_sh} - {18'd0, dsr_reg};
    assign q_signed = neg_reg ? (~quo_reg + 37'd1) : quo_reg;
    assign quotient = q_signed[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy <= 1'b1;
            cnt_reg <= 6'd37;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[36];
            quo_reg <= dividend[36] ? 37'(-dividend) : 37'(dividend);
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy) begin
            if (!trial[37]) begin
                rem_reg <= trial[36:0];
                quo_reg <= {quo_reg[35:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[35:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

>>> src/arim_back.sv
// Back end: sample processing, statistics, recorder control and result register.
`default_nettype none
module arim_back
    import arim_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire req_t        q_req,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [151:0]     m_tdata,
    output logic             m_tuser
);
    logic [1:0]  act_ch_reg;
    logic        thr_en_reg;
    logic [15:0] thr_lvl_reg;
    logic [31:0] max_dur_reg;
    logic [19:0] dc_win_reg;

    state_t state_reg, state_next;
    req_t   req_reg;
    logic   started_reg, waiting_reg;
    logic [31:0] frames_reg, clip_reg;
    logic [15:0] peak_reg [2];
    logic signed [36:0] sum_reg [2];
    logic [19:0] dcnt_reg;
    logic signed [15:0] dcoff_reg [2];
    logic signed [17:0] comp_reg [2];
    logic signed [15:0] s_reg [2];
    logic [15:0] mag_reg [2];
    logic        ch2_reg, div_ch_reg;
    logic        wv_reg, ls_reg;
    logic [31:0] widx_reg;
    logic [15:0] pk_reg;

    logic        div_busy;
    logic signed [15:0] div_q;
    logic signed [36:0] div_a;
    logic        do_div_reg;
    logic        out_free;

    logic [1:0] nch;
    assign nch = (act_ch_reg == 2'd0) ? 2'd1 :
                 (act_ch_reg > 2'(CHANNELS)) ? 2'(CHANNELS) : act_ch_reg;

    // result register can take a new result this cycle
    assign out_free = !m_tvalid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_ch_reg <= 2'd2; thr_en_reg <= 1'b0; thr_lvl_reg <= '0;
            max_dur_reg <= '0; dc_win_reg <= 20'd220500;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_CHANNELS:  act_ch_reg <= cfg_wdata[1:0];
                CFG_THR_EN:    thr_en_reg <= cfg_wdata[0];
                CFG_THR_LEVEL: thr_lvl_reg <= cfg_wdata[15:0];
                CFG_MAX_DUR:   max_dur_reg <= cfg_wdata;
                CFG_DC_WINDOW: dc_win_reg <= cfg_wdata[19:0];
                default: ;
            endcase
        end
    end

    // sample path: compensate and clip, combinational from registered request
    logic signed [17:0] raw_c [2];
    logic signed [15:0] s_c [2];
    always_comb begin
        raw_c[0] = 18'(req_reg.smp_l) + comp_reg[0];
        raw_c[1] = 18'(req_reg.smp_r) + comp_reg[1];
        for (int c = 0; c < 2; c++) begin
            if (raw_c[c] > 18'(FULL_SCALE)) s_c[c] = 16'sd32767;
            else if (raw_c[c] < -18'(FULL_SCALE)) s_c[c] = -16'sd32767;
            else s_c[c] = raw_c[c][15:0];
        end
    end

    assign div_a = div_ch_reg ? sum_reg[1] : sum_reg[0];

    logic div_go;
    assign div_go = (state_reg == ST_DIVIDE) && !div_busy && !do_div_reg;

    arim_div u_div (
        .aclk, .aresetn, .start(div_go), .dividend(div_a), .divisor(dcnt_reg),
        .busy(div_busy), .quotient(div_q)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (q_valid && out_free) state_next = ST_SAMPLE;
            ST_SAMPLE: state_next = ST_UPDATE;
            ST_UPDATE: state_next = ((req_reg.op == OP_FRAME) &&
                                     (dcnt_reg + 20'd1 >= dc_win_reg)) ? ST_DIVIDE
                                                                      : ST_OUTPUT;
            ST_DIVIDE: if (do_div_reg && !div_busy &&
                           (div_ch_reg || ch2_reg == 1'b0) ) state_next = ST_OUTPUT;
            ST_OUTPUT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign q_ready = (state_reg == ST_IDLE) && out_free;

    logic meets;
    logic [31:0] fw_inc;
    logic [1:0]  clip_inc;
    logic [32:0] clip_sum;
    logic [31:0] clip_next;
    always_comb begin
        meets = (mag_reg[0] >= thr_lvl_reg) || (ch2_reg && mag_reg[1] >= thr_lvl_reg);
        fw_inc = (frames_reg != '1) ? frames_reg + 32'd1 : frames_reg;
        clip_inc = 2'(mag_reg[0] >= 16'd32767) + 2'(ch2_reg && mag_reg[1] >= 16'd32767);
        clip_sum = {1'b0, clip_reg} + {31'd0, clip_inc};
        clip_next = clip_sum[32] ? '1 : clip_sum[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_tvalid <= 1'b0;
            started_reg <= 1'b0; waiting_reg <= 1'b0;
            frames_reg <= '0; clip_reg <= '0; dcnt_reg <= '0;
            do_div_reg <= 1'b0; div_ch_reg <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                peak_reg[c] <= '0; sum_reg[c] <= '0; dcoff_reg[c] <= '0; comp_reg[c] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUTPUT && out_free) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (q_valid && out_free) begin
                    req_reg <= q_req;
                    ch2_reg <= (nch == 2'd2);
                    widx_reg <= frames_reg;
                    wv_reg <= 1'b0; ls_reg <= 1'b0; pk_reg <= '0;
                end
                ST_SAMPLE: begin
                    for (int c = 0; c < 2; c++) begin
                        mag_reg[c] <= s_c[c][15] ? 16'(-s_c[c]) : 16'(s_c[c]);
                    end
                    s_reg[0] <= (req_reg.op == OP_FRAME) ? s_c[0] : '0;
                    s_reg[1] <= (req_reg.op == OP_FRAME && ch2_reg) ? s_c[1] : '0;
                end
                ST_UPDATE: begin
                    unique case (req_reg.op)
                        OP_FRAME: begin
                            clip_reg <= clip_next;
                            if (mag_reg[0] > peak_reg[0]) peak_reg[0] <= mag_reg[0];
                            sum_reg[0] <= sum_reg[0] + 37'(s_reg[0]);
                            if (ch2_reg) begin
                                if (mag_reg[1] > peak_reg[1]) peak_reg[1] <= mag_reg[1];
                                sum_reg[1] <= sum_reg[1] + 37'(s_reg[1]);
                            end
                            dcnt_reg <= dcnt_reg + 20'd1;
                            do_div_reg <= 1'b0; div_ch_reg <= 1'b0;
                            if (started_reg && (!waiting_reg || meets)) begin
                                if (max_dur_reg != '0 && frames_reg >= max_dur_reg) begin
                                    started_reg <= 1'b0; waiting_reg <= 1'b0; ls_reg <= 1'b1;
                                end else begin
                                    waiting_reg <= 1'b0;
                                    wv_reg <= 1'b1;
                                    frames_reg <= fw_inc;
                                    if (max_dur_reg != '0 && fw_inc >= max_dur_reg) begin
                                        started_reg <= 1'b0;
                                        ls_reg <= 1'b1;
                                    end
                                end
                            end
                        end
                        OP_START: if (!started_reg) begin
                            started_reg <= 1'b1; waiting_reg <= thr_en_reg; frames_reg <= '0;
                        end
                        OP_STOP: begin started_reg <= 1'b0; waiting_reg <= 1'b0; end
                        OP_PEAK: begin
                            pk_reg <= peak_reg[req_reg.peak_ch];
                            peak_reg[req_reg.peak_ch] <= '0;
                        end
                        OP_DCAPPLY: for (int c = 0; c < 2; c++) begin
                            if (comp_reg[c] - 18'(dcoff_reg[c]) > COMP_LIMIT)
                                comp_reg[c] <= COMP_LIMIT;
                            else if (comp_reg[c] - 18'(dcoff_reg[c]) < -COMP_LIMIT)
                                comp_reg[c] <= -COMP_LIMIT;
                            else comp_reg[c] <= comp_reg[c] - 18'(dcoff_reg[c]);
                        end
                        OP_RESTART: frames_reg <= '0;
                        default: ;
                    endcase
                end
                ST_DIVIDE: begin
                    // dcnt_reg now holds the window count; one channel at a time
                    if (div_go) do_div_reg <= 1'b1;
                    else if (do_div_reg && !div_busy) begin
                        dcoff_reg[div_ch_reg] <= div_q;
                        sum_reg[div_ch_reg] <= '0;
                        do_div_reg <= 1'b0;
                        if (div_ch_reg || !ch2_reg) dcnt_reg <= '0;
                        else div_ch_reg <= 1'b1;
                    end
                end
                ST_OUTPUT: if (out_free) begin
                    m_tdata <= {5'd0, ls_reg, dcoff_reg[1], dcoff_reg[0], pk_reg, clip_reg,
                                started_reg && waiting_reg, started_reg, widx_reg,
                                s_reg[1], s_reg[0]};
                    m_tuser <= wv_reg;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> src/audio_record_input_monitor.sv
// Top level of the record input monitor.
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tdata: sample_left, sample_right, peak_channel; tuser: op
//  m_      | out | m_tvalid/m_tready  | tdata: status fields; tuser: write_valid
//  cfg     | in  | cfg_we             | cfg_addr, cfg_wdata
// A request passes through the back-end states pick up, sample, update and output;
// the result is registered on leaving output, and no further request is picked up before then.
// A frame closing the DC window also passes through divide, one divider run per active channel.
// The back end waits in output only while an unaccepted result is held; the
// two-entry queue keeps taking requests meanwhile until it fills.
// Synchronous reset (aresetn low) sets configuration to its defaults and clears statistics and flags.
`default_nettype none
module audio_record_input_monitor
    import arim_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // sample_left, sample_right, peak_channel
    input  wire logic [2:0]  s_tuser,  // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [151:0]     m_tdata,  // out_left, out_right, write_index, recording,
                                       // waiting_threshold, clipped_total, peak_value,
                                       // dc_left, dc_right, limit_stop
    output logic             m_tuser   // write_valid
);
    req_t in_req, q_req;
    logic q_valid, q_ready;
    assign in_req = '{op: op_t'(s_tuser), smp_l: s_tdata[15:0], smp_r: s_tdata[31:16],
                      peak_ch: s_tdata[32]};
    logic unused_ok;
    assign unused_ok = ^s_tdata[39:33];

    arim_front u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready), .in_req,
        .q_valid, .q_ready, .q_req
    );
    arim_back #(.CHANNELS(CHANNELS)) u_back (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .q_valid, .q_ready, .q_req, .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );
endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the record input monitor: directed and random requests.
module testbench;
    import arim_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic        m_tuser;

    audio_record_input_monitor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    typedef struct {
        logic        write_valid;
        logic [15:0] out_left;
        logic [15:0] out_right;
        logic [31:0] write_index;
        logic        recording;
        logic        waiting;
        logic [31:0] clipped_total;
        logic [15:0] peak_value;
        logic [15:0] dc_left;
        logic [15:0] dc_right;
        logic        limit_stop;
    } monitor_status_t;

    monitor_status_t status_fifo[$];
    int errors = 0;

    // mirror of the block's registers and state
    int unsigned active_ch = 2, thr_en = 0, thr_level = 0, max_dur = 0, dc_window = 220500;
    bit          started = 0, waiting = 0;
    int unsigned frames_written = 0, clip_count = 0, dc_count = 0;
    int unsigned peak_mag[2];
    longint      dc_acc[2];
    int          dc_offset[2];
    int          dc_comp[2];

    // sender burst control, receiver stall control
    bit gaps_on = 1;
    int burst_left = 0;
    int stall_mode = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int hold_cnt = 0;
    int cyc = 0;

    initial aclk = 0;
    always #1 aclk = ~aclk;

    function automatic int clamp(int v, int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic monitor_status_t predict_status(op_t op, logic [15:0] l, logic [15:0] r,
                                                       logic pch);
        monitor_status_t res;
        int unsigned nch;
        int raw[2];
        int smp[2];
        int s;
        int unsigned mag;
        bit meets;
        bit go;
        res.write_valid = 0;
        res.limit_stop = 0;
        res.peak_value = 0;
        res.write_index = frames_written;
        raw[0] = $signed(l);
        raw[1] = $signed(r);
        smp[0] = 0;
        smp[1] = 0;
        nch = (active_ch < 1) ? 1 : (active_ch > 2) ? 2 : active_ch;
        case (op)
            OP_FRAME: begin
                meets = 0;
                for (int c = 0; c < nch; c++) begin
                    s = clamp(raw[c] + dc_comp[c], 32767);
                    mag = (s < 0) ? -s : s;
                    smp[c] = s;
                    if (mag >= 32767 && clip_count != 32'hFFFF_FFFF) clip_count++;
                    if (mag > peak_mag[c]) peak_mag[c] = mag;
                    dc_acc[c] += s;
                    if (mag >= thr_level) meets = 1;
                end
                dc_count++;
                if (dc_count >= dc_window) begin
                    for (int c = 0; c < nch; c++) begin
                        dc_offset[c] = int'(dc_acc[c] / longint'(dc_count));
                        dc_acc[c] = 0;
                    end
                    dc_count = 0;
                end
                if (started) begin
                    go = 1;
                    if (waiting) begin
                        if (meets) waiting = 0;
                        else go = 0;
                    end
                    if (go) begin
                        if (max_dur != 0 && frames_written >= max_dur) begin
                            started = 0; waiting = 0; res.limit_stop = 1;
                        end else begin
                            res.write_valid = 1;
                            if (frames_written != 32'hFFFF_FFFF) frames_written++;
                            if (max_dur != 0 && frames_written >= max_dur) begin
                                started = 0; waiting = 0; res.limit_stop = 1;
                            end
                        end
                    end
                end
            end
            OP_START: begin
                if (!started) begin
                    started = 1;
                    waiting = (thr_en != 0);
                    frames_written = 0;
                end
            end
            OP_STOP: begin
                started = 0;
                waiting = 0;
            end
            OP_PEAK: begin
                res.peak_value = peak_mag[pch];
                peak_mag[pch] = 0;
            end
            OP_DCAPPLY: begin
                for (int c = 0; c < 2; c++) dc_comp[c] = clamp(dc_comp[c] - dc_offset[c], 65535);
            end
            OP_RESTART: frames_written = 0;
            default: ;
        endcase
        res.out_left = smp[0][15:0];
        res.out_right = smp[1][15:0];
        res.recording = started;
        res.waiting = started && waiting;
        res.clipped_total = clip_count;
        res.dc_left = dc_offset[0][15:0];
        res.dc_right = dc_offset[1][15:0];
        return res;
    endfunction

    task automatic send_req(op_t op, logic [15:0] l, logic [15:0] r, logic pch);
        if (gaps_on && burst_left == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {7'd0, pch, r, l};
        do @(posedge aclk); while (!s_tready);
        status_fifo = {status_fifo, predict_status(op, l, r, pch)};
    endtask

    task automatic frame(logic [15:0] l, logic [15:0] r);
        send_req(OP_FRAME, l, r, 1'b0);
    endtask

    // drain, let the divider settle, then write one register
    task automatic cfg_write(cfg_idx_t idx, logic [31:0] val);
        s_tvalid <= 0;
        while (status_fifo.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        case (idx)
            CFG_CHANNELS:  active_ch = val & 3;
            CFG_THR_EN:    thr_en = val & 1;
            CFG_THR_LEVEL: thr_level = val & 16'hFFFF;
            CFG_MAX_DUR:   max_dur = val;
            CFG_DC_WINDOW: dc_window = val & 20'hFFFFF;
            default: ;
        endcase
    endtask

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // result checker and receiver stall pattern
    always @(posedge aclk) begin
        monitor_status_t e;
        cyc <= cyc + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (status_fifo.size() == 0) begin
                $error("result with no request pending");
                errors++;
            end else begin
                e = status_fifo.pop_front();
                check_field("write_valid", e.write_valid, m_tuser);
                check_field("out_left", e.out_left, m_tdata[15:0]);
                check_field("out_right", e.out_right, m_tdata[31:16]);
                check_field("write_index", e.write_index, m_tdata[63:32]);
                check_field("recording", e.recording, m_tdata[64]);
                check_field("waiting_threshold", e.waiting, m_tdata[65]);
                check_field("clipped_total", e.clipped_total, m_tdata[97:66]);
                check_field("peak_value", e.peak_value, m_tdata[113:98]);
                check_field("dc_left", e.dc_left, m_tdata[129:114]);
                check_field("dc_right", e.dc_right, m_tdata[145:130]);
                check_field("limit_stop", e.limit_stop, m_tdata[146]);
            end
        end
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 0;
        end else if (holds_done < hold_requests) begin
            holds_done <= holds_done + 1;
            hold_cnt <= 300;
            m_tready <= 0;
        end else begin
            case (stall_mode)
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ((cyc % 7) >= 3);
                default: m_tready <= 1;
            endcase
        end
    end

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h8001;
            3, 4: return 16'($signed($urandom_range(0, 2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_defaults();
        frame(16'h0000, 16'h0000);
        send_req(OP_PEAK, 16'h0, 16'h0, 1'b0);
        send_req(OP_NONE6, 16'hFFFF, 16'hFFFF, 1'b1);
        send_req(OP_NONE7, 16'h1234, 16'h5678, 1'b0);
    endtask

    task automatic test_extremes();
        frame(16'h7FFF, 16'h8000);
        frame(16'h8000, 16'h7FFF);
        frame(16'h8001, 16'h0001);
        send_req(OP_PEAK, 16'h0, 16'h0, 1'b0);
        send_req(OP_PEAK, 16'h0, 16'h0, 1'b1);
    endtask

    task automatic test_threshold();
        cfg_write(CFG_THR_EN, 1);
        cfg_write(CFG_THR_LEVEL, 1000);
        send_req(OP_START, 16'h0, 16'h0, 1'b0);
        frame(16'd10, 16'hFFF6);
        frame(16'd5, 16'd2000);
        frame(16'd1, 16'd1);
        send_req(OP_STOP, 16'h0, 16'h0, 1'b0);
        cfg_write(CFG_THR_EN, 0);
    endtask

    task automatic test_duration();
        cfg_write(CFG_MAX_DUR, 2);
        send_req(OP_START, 16'h0, 16'h0, 1'b0);
        frame(16'd3, 16'd4);
        send_req(OP_START, 16'h0, 16'h0, 1'b0);   // already started: no effect
        frame(16'd5, 16'd6);
        frame(16'd7, 16'd8);
        // limit no higher than the frames already written stops at once
        send_req(OP_START, 16'h0, 16'h0, 1'b0);
        frame(16'd1, 16'd1);
        cfg_write(CFG_MAX_DUR, 1);
        frame(16'd1, 16'd1);
        send_req(OP_RESTART, 16'h0, 16'h0, 1'b0);
        send_req(OP_STOP, 16'h0, 16'h0, 1'b0);
        cfg_write(CFG_MAX_DUR, 0);
    endtask

    task automatic test_dc_and_channels();
        cfg_write(CFG_DC_WINDOW, 2);
        frame(16'd1001, 16'hFC17);
        frame(16'd1000, 16'hFC18);
        send_req(OP_DCAPPLY, 16'h0, 16'h0, 1'b0);
        frame(16'd0, 16'd0);
        cfg_write(CFG_DC_WINDOW, 0);
        frame(16'd7, 16'hFFF9);
        cfg_write(CFG_CHANNELS, 1);
        frame(16'h7FFF, 16'h7FFF);
        cfg_write(CFG_CHANNELS, 0);
        frame(16'h8000, 16'h8000);
        cfg_write(CFG_CHANNELS, 3);
        frame(16'h0100, 16'h0200);
    endtask

    task automatic test_backpressure();
        gaps_on = 0;
        hold_requests = hold_requests + 1;
        send_req(OP_START, 16'h0, 16'h0, 1'b0);
        repeat (20) frame(rand_sample(), rand_sample());
        send_req(OP_STOP, 16'h0, 16'h0, 1'b0);
        gaps_on = 1;
    endtask

    task automatic test_random();
        int unsigned lev, dur, win, k;
        op_t op;
        for (int ph = 0; ph < 6; ph++) begin
            case ($urandom_range(0, 3))
                0: lev = 0;
                1: lev = 32768;
                2: lev = 500;
                default: lev = $urandom_range(0, 32768);
            endcase
            case ($urandom_range(0, 3))
                0: dur = 0;
                1: dur = 1;
                2: dur = 32'hFFFF_FFFF;
                default: dur = $urandom_range(2, 50);
            endcase
            win = (ph == 0) ? 20'hFFFFF : (ph == 1) ? 1 : $urandom_range(0, 16);
            cfg_write(CFG_CHANNELS, (ph == 2) ? 1 : (ph == 3) ? 2 : $urandom_range(0, 3));
            cfg_write(CFG_THR_EN, $urandom_range(0, 1));
            cfg_write(CFG_THR_LEVEL, lev);
            cfg_write(CFG_MAX_DUR, dur);
            cfg_write(CFG_DC_WINDOW, win);
            stall_mode = ph % 3;
            if (ph == 4) hold_requests = hold_requests + 1;
            for (int i = 0; i < 250; i++) begin
                k = $urandom_range(0, 99);
                if (k < 70) op = OP_FRAME;
                else if (k < 79) op = OP_START;
                else if (k < 83) op = OP_STOP;
                else if (k < 89) op = OP_PEAK;
                else if (k < 94) op = OP_DCAPPLY;
                else if (k < 97) op = OP_RESTART;
                else op = op_t'($urandom_range(6, 7));
                send_req(op, rand_sample(), rand_sample(), 1'($urandom));
            end
        end
    endtask

    initial begin
        aresetn = 0;
        cfg_we = 0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        peak_mag = '{0, 0};
        dc_acc = '{0, 0};
        dc_offset = '{0, 0};
        dc_comp = '{0, 0};
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        stall_mode = 1;
        test_defaults();
        test_extremes();
        test_threshold();
        test_duration();
        test_dc_and_channels();
        test_backpressure();
        test_random();
        s_tvalid <= 0;
        while (status_fifo.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end
endmodule

>>> sim.f
src/arim_pkg.sv
src/arim_front.sv
src/arim_div.sv
src/arim_back.sv
src/audio_record_input_monitor.sv
test/testbench.sv
